// File: hw/rtl/section_deframer_crc_check_core_macros.svh
// Assertion helpers shared by the deframer RTL.
// Every check is clocked on clk_i and held off while rst_ni is low.
`ifndef SECTION_DEFRAMER_CRC_CHECK_CORE_MACROS_SVH
`define SECTION_DEFRAMER_CRC_CHECK_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every clock edge.
`define SDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that expr never becomes true.
`define SDC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`else

`define SDC_ASSERT(lbl, prop, msg)
`define SDC_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: hw/rtl/sdcrc_pkg.sv
`timescale 1ns / 1ps

package sdcrc_pkg;

  // Widest payload length a section may declare.
  localparam int unsigned LENGTH_BITS = 32;
  localparam logic [63:0] LEN_LIMIT   = 64'(~64'd0 >> (64 - LENGTH_BITS));

  // Varint byte index from which only the top length bit remains.
  localparam logic [3:0]  VARINT_LAST = 4'd9;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAY  = 3'd2,
    PH_CRC  = 3'd3,
    PH_SKIP = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD_CRC = 3'd2,
    KIND_TRUNC   = 3'd3,
    KIND_BAD_LEN = 3'd4
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  stype;
    logic [7:0]  pbyte;
    logic [31:0] plen;
  } res_t;

  // Reflected CRC-32C update by one byte.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Clamp a 64-bit length to 32 bits.
  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// File: hw/rtl/sdcrc_parser.sv
`timescale 1ns / 1ps

`include "section_deframer_crc_check_core_macros.svh"

module sdcrc_parser
  import sdcrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_mark_i,
  input  logic [31:0] max_length_i,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] accum_q, accum_d;
  logic [3:0]  vcnt_q, vcnt_d;
  logic [31:0] left_q, left_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] scrc_q, scrc_d;
  logic [1:0]  ccnt_q, ccnt_d;

  logic [63:0] acc_new;
  logic [5:0]  shamt;
  logic [31:0] crc_upd;
  logic [31:0] scrc_new;
  logic        len_bad;

  assign crc_upd = crc32c_byte(crc_q, data_byte_i);
  // 7 * count, modulo 64
  assign shamt   = 6'({2'd0, vcnt_q} << 3) - 6'({2'd0, vcnt_q});

  always_comb begin
    if (vcnt_q >= VARINT_LAST) begin
      acc_new = accum_q | {data_byte_i[0], 63'd0};
    end else begin
      acc_new = accum_q | ({57'd0, data_byte_i[6:0]} << shamt);
    end
    len_bad = (acc_new > {32'd0, max_length_i}) || (acc_new > LEN_LIMIT);
  end

  always_comb begin
    scrc_new = scrc_q;
    case (ccnt_q)
      2'd0:    scrc_new[7:0]   = data_byte_i;
      2'd1:    scrc_new[15:8]  = data_byte_i;
      2'd2:    scrc_new[23:16] = data_byte_i;
      default: scrc_new[31:24] = data_byte_i;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    accum_d = accum_q;
    vcnt_d  = vcnt_q;
    left_d  = left_q;
    crc_d   = crc_q;
    scrc_d  = scrc_q;
    ccnt_d  = ccnt_q;

    res_o       = '0;
    res_o.kind  = KIND_BYTE;
    res_o.stype = type_q;

    if (step_i && end_mark_i) begin
      unique case (phase_q)
        PH_TYPE: ;
        PH_LEN, PH_PAY, PH_CRC: begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_TRUNC;
          res_o.plen  = (phase_q == PH_LEN) ? 32'd0 : sat32(accum_q);
          phase_d = PH_TYPE;
          accum_d = '0;
          vcnt_d  = '0;
          left_d  = '0;
          crc_d   = CRC_INIT;
          scrc_d  = '0;
          ccnt_d  = '0;
        end
        default: begin
          phase_d = PH_TYPE;
          accum_d = '0;
          vcnt_d  = '0;
          left_d  = '0;
          crc_d   = CRC_INIT;
          scrc_d  = '0;
          ccnt_d  = '0;
        end
      endcase
    end else if (step_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          type_d  = data_byte_i;
          crc_d   = crc32c_byte(CRC_INIT, data_byte_i);
          accum_d = '0;
          vcnt_d  = '0;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          crc_d = crc_upd;
          if ((vcnt_q >= VARINT_LAST) && (|data_byte_i[7:1])) begin
            phase_d     = PH_SKIP;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BAD_LEN;
          end else begin
            accum_d = acc_new;
            vcnt_d  = vcnt_q + 4'd1;
            if (!data_byte_i[7]) begin
              if (len_bad) begin
                phase_d     = PH_SKIP;
                res_o.valid = 1'b1;
                res_o.kind  = KIND_BAD_LEN;
                res_o.plen  = sat32(acc_new);
              end else begin
                left_d  = acc_new[31:0];
                scrc_d  = '0;
                ccnt_d  = '0;
                phase_d = (acc_new == 64'd0) ? PH_CRC : PH_PAY;
              end
            end
          end
        end
        PH_PAY: begin
          crc_d  = crc_upd;
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            phase_d = PH_CRC;
          end
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BYTE;
          res_o.pbyte = data_byte_i;
          res_o.plen  = sat32(accum_q);
        end
        PH_CRC: begin
          scrc_d = scrc_new;
          if (ccnt_q != 2'd3) begin
            ccnt_d = ccnt_q + 2'd1;
          end else begin
            res_o.valid = 1'b1;
            res_o.plen  = sat32(accum_q);
            if ((crc_q ^ CRC_INIT) == scrc_new) begin
              res_o.kind = KIND_GOOD;
              phase_d    = PH_TYPE;
            end else begin
              res_o.kind = KIND_BAD_CRC;
              phase_d    = PH_SKIP;
            end
            accum_d = '0;
            vcnt_d  = '0;
            left_d  = '0;
            crc_d   = CRC_INIT;
            scrc_d  = '0;
            ccnt_d  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      accum_q <= '0;
      vcnt_q  <= '0;
      left_q  <= '0;
      crc_q   <= CRC_INIT;
      scrc_q  <= '0;
      ccnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      accum_q <= accum_d;
      vcnt_q  <= vcnt_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      scrc_q  <= scrc_d;
      ccnt_q  <= ccnt_d;
    end
  end

  `SDC_ASSERT(a_pay_has_bytes, (phase_q == PH_PAY) |-> (left_q != 32'd0), "payload phase with no bytes left")
  `SDC_ASSERT(a_crc_cnt_phase, (ccnt_q != 2'd0) |-> (phase_q == PH_CRC), "crc byte count outside crc phase")
  `SDC_ASSERT(a_varint_bound, vcnt_q <= (VARINT_LAST + 4'd1), "varint count beyond ten bytes")

endmodule

// File: hw/rtl/section_deframer_crc_check_core.sv
`timescale 1ns / 1ps

`include "section_deframer_crc_check_core_macros.svh"

// Section deframer with CRC-32C check. The input is a byte stream of sections:
// a type byte, an unsigned LEB128 payload length, the payload, and a
// little-endian CRC-32C over type, length and payload. Every payload byte goes
// out as an item of kind 0 as soon as it arrives; after the fourth CRC byte one
// item reports section good (1) or CRC mismatch (2), and the consumer must drop
// the payload it already took on a mismatch. An end mark inside a section gives
// a truncated item (3); a varint over ten bytes or a length above max_length
// gives a bad length item (4). After any error the block discards bytes up to
// the next end mark. Throughput is one input item per clock with no bubbles
// while out_stall_i is low; an accepted item waits in the input register, and
// its result loads into the result register when that item advances. The
// clock period is set by the byte-wide CRC-32C update plus the 64-bit varint
// merge and length compare that sit between those two registers. Items that
// yield no result (type, length and CRC bytes, end marks between sections)
// are consumed silently. Write max_length only while the block is idle; the
// write port is always ready.

module section_deframer_crc_check_core
  import sdcrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,

  // input item
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_mark_i,

  // result item
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  section_type_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] payload_length_o
);

  logic [31:0] max_len_q;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic        in_end_q;

  logic        out_vld_q, out_vld_d;
  kind_e       out_kind_q;
  logic [7:0]  out_type_q;
  logic [7:0]  out_pbyte_q;
  logic [31:0] out_plen_q;

  logic        in_accept;
  logic        out_free;
  logic        advance;
  res_t        res;

  // Config register: always ready, writes land directly.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 32'hFFFF_FFFF;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // The result register frees up when empty or when its item is taken this
  // cycle, so the input register can advance and refill in the same cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = res.valid;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: load on handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= end_mark_i;
    end
    if (advance && res.valid) begin
      out_kind_q  <= res.kind;
      out_type_q  <= res.stype;
      out_pbyte_q <= res.pbyte;
      out_plen_q  <= res.plen;
    end
  end

  // Section state and the per-byte work; state advances with the input item.
  sdcrc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (in_byte_q),
    .end_mark_i   (in_end_q),
    .max_length_i (max_len_q),
    .res_o        (res)
  );

  assign out_valid_o      = out_vld_q;
  assign kind_o           = out_kind_q;
  assign section_type_o   = out_type_q;
  assign payload_byte_o   = out_pbyte_q;
  assign payload_length_o = out_plen_q;

  `SDC_ASSERT(a_in_hold, (in_vld_q && !out_free) |=> in_vld_q, "input item lost while blocked")
  `SDC_ASSERT(a_pbyte_zero, (out_vld_q && (out_kind_q != KIND_BYTE)) |-> (out_pbyte_q == 8'd0), "status item carries a payload byte")
  `SDC_ASSERT_NEVER(a_byte_len, out_vld_q && (out_kind_q == KIND_BYTE) && (out_plen_q == 32'd0), "payload byte from zero-length section")

endmodule
